FILE: sv/bdy_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdy_pkg
// Shared types, register codes and colour constants of the Bayer demosaic.
// ----------------------------------------------------------------------------
package bdy_pkg;

    localparam int PIX_W     = 10;
    localparam int OUT_W     = 8;
    localparam int OCOL_W    = 11;
    localparam int OROW_W    = 12;
    localparam int WP_W      = 11;
    localparam int HP_W      = 12;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic REG_WIDTH_PAIRS  = 1'b0;
    localparam logic REG_HEIGHT_PAIRS = 1'b1;

    localparam logic [WP_W-1:0] WP_RESET = 11'd320;
    localparam logic [HP_W-1:0] HP_RESET = 12'd240;

    // BT.601 limited range, 8-bit fixed point
    localparam int Y_R    = 66;
    localparam int Y_G    = 129;
    localparam int Y_B    = 25;
    localparam int RND    = 128;
    localparam int Y_OFF  = 16;
    localparam int CB_R   = 38;
    localparam int CB_G   = 74;
    localparam int CB_B   = 112;
    localparam int CR_R   = 112;
    localparam int CR_G   = 94;
    localparam int CR_B   = 18;
    localparam int C_BIAS = 32768 + 128;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [OUT_W-1:0] byte_t;
    // [row: ym y0 y1 yp][col: xm x0 x1 xp]
    typedef logic [3:0][3:0][PIX_W-1:0] grid_t;
    typedef logic [3:0][1:0] sel_t;

    localparam int GRID_W = 16 * PIX_W;

    typedef struct packed {
        logic [WP_W-1:0] width_pairs;
        logic [HP_W-1:0] height_pairs;
        logic            restart;
    } cfg_t;

    function automatic byte_t to8(input pix_t v);
        logic [PIX_W:0] t;
        t = {1'b0, v} + 11'd2;
        return t[PIX_W] ? 8'hFF : t[PIX_W-1:2];
    endfunction

    function automatic pix_t avg4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
        logic [PIX_W+1:0] s;
        s = 12'(a) + 12'(b) + 12'(c) + 12'(d);
        return s[PIX_W+1:2];
    endfunction

    function automatic pix_t avg2(input pix_t a, input pix_t b);
        logic [PIX_W:0] s;
        s = 11'(a) + 11'(b);
        return s[PIX_W:1];
    endfunction

endpackage
`default_nettype wire

FILE: sv/bdy_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdy_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdy_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/bdy_jobq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdy_jobq
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module bdy_jobq #(
    parameter int WIDTH = 183,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty,
    output logic                  afull
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CNTW-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rptr_reg];
    assign empty = (count_reg == '0);
    // one slot kept back for the request still in the front's second stage
    assign afull = (32'(count_reg) >= DEPTH - 1);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) != DEPTH))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("job queue underflow");
`endif

endmodule
`default_nettype wire

FILE: sv/bdy_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdy_front
// Raster counters, four line stores and the 4x4 window; issues block requests.
// ----------------------------------------------------------------------------
module bdy_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int JOB_W = bdy_pkg::GRID_W + CW + RW
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bdy_pkg::cfg_t         cfg,
    input  wire logic                  push,
    input  wire logic [bdy_pkg::PIX_W-1:0] raw_pixel,
    output logic                       full,
    input  wire logic                  q_afull,
    output logic                       job_push,
    output logic      [JOB_W-1:0]      job_data
);

    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] wp_eff, wlast;
    logic [RW-1:0] hp_eff, hlast;
    logic          accept;
    logic          col_norm, col_last, row_norm, row_last, emit;
    logic [CW-1:0] bx;
    logic [RW-1:0] by;
    bdy_pkg::sel_t rsel, csel;
    logic [1:0]    slot;

    logic          s1_v_reg, s1_emit_reg;
    bdy_pkg::pix_t s1_pix_reg;
    logic [1:0]    s1_slot_reg;
    bdy_pkg::sel_t s1_rsel_reg, s1_csel_reg;
    logic [CW-1:0] s1_bx_reg;
    logic [RW-1:0] s1_by_reg;

    logic [3:0][bdy_pkg::PIX_W-1:0]      ram_q;
    logic [3:0][2:0][bdy_pkg::PIX_W-1:0] win_reg;
    logic [3:0][3:0][bdy_pkg::PIX_W-1:0] view;
    bdy_pkg::grid_t                      grid;

    always_comb
    begin
        if (cfg.width_pairs == '0)
            wp_eff = CW'(1);
        else if (32'(cfg.width_pairs) > MAX_WIDTH / 2)
            wp_eff = CW'(MAX_WIDTH / 2);
        else
            wp_eff = CW'(cfg.width_pairs);
        if (cfg.height_pairs == '0)
            hp_eff = RW'(1);
        else if (32'(cfg.height_pairs) > MAX_HEIGHT / 2)
            hp_eff = RW'(MAX_HEIGHT / 2);
        else
            hp_eff = RW'(cfg.height_pairs);
    end

    assign wlast = CW'({wp_eff, 1'b0} - 1'b1);
    assign hlast = RW'({hp_eff, 1'b0} - 1'b1);

    assign full   = q_afull;
    assign accept = push && !full;
    assign slot   = 2'(r_reg);

    // a block goes out once its bottom-right neighbour, or the row end or last row, arrives
    always_comb
    begin
        col_norm = !c_reg[0] && (32'(c_reg) >= 2);
        col_last = !col_norm && (c_reg == wlast);
        row_norm = !r_reg[0] && (32'(r_reg) >= 2);
        row_last = !row_norm && (r_reg == hlast);
        emit     = (col_norm || col_last) && (row_norm || row_last);
        // window ages: 0 newest, 3 oldest
        if (col_norm)
        begin
            bx   = CW'(c_reg - 2'd2);
            csel = {2'd0, 2'd1, 2'd2, (32'(c_reg) == 2) ? 2'd2 : 2'd3};
        end
        else
        begin
            bx   = CW'(c_reg - 1'b1);
            csel = {2'd0, 2'd0, 2'd1, (32'(c_reg) == 1) ? 2'd1 : 2'd2};
        end
        if (row_norm)
        begin
            by   = RW'(r_reg - 2'd2);
            rsel = {2'd0, 2'd1, 2'd2, (32'(r_reg) == 2) ? 2'd2 : 2'd3};
        end
        else
        begin
            by   = RW'(r_reg - 1'b1);
            rsel = {2'd0, 2'd0, 2'd1, (32'(r_reg) == 1) ? 2'd1 : 2'd2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg       <= '0;
            r_reg       <= '0;
            s1_v_reg    <= 1'b0;
            s1_emit_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg    <= accept;
            s1_emit_reg <= accept && emit;
            if (cfg.restart)
            begin
                c_reg <= '0;
                r_reg <= '0;
            end
            else if (accept)
            begin
                if (c_reg == wlast)
                begin
                    c_reg <= '0;
                    r_reg <= (r_reg == hlast) ? '0 : r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= raw_pixel;
            s1_slot_reg <= slot;
            s1_rsel_reg <= rsel;
            s1_csel_reg <= csel;
            s1_bx_reg   <= bx;
            s1_by_reg   <= by;
        end
        if (s1_v_reg)
        begin
            for (int a = 0; a < 4; a++)
            begin
                win_reg[a][0] <= view[a][0];
                win_reg[a][1] <= win_reg[a][0];
                win_reg[a][2] <= win_reg[a][1];
            end
        end
    end

    for (genvar m = 0; m < 4; m++)
    begin : g_line
        bdy_ram #(
            .WIDTH (bdy_pkg::PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && (slot == 2'(m))),
            .waddr (c_reg),
            .wdata (raw_pixel),
            .re    (accept),
            .raddr (c_reg),
            .rdata (ram_q[m])
        );
    end

    always_comb
    begin
        view[0][0] = s1_pix_reg;
        for (int a = 1; a < 4; a++)
        begin
            view[a][0] = ram_q[2'(s1_slot_reg - 2'(a))];
        end
        for (int a = 0; a < 4; a++)
        begin
            for (int k = 1; k < 4; k++)
            begin
                view[a][k] = win_reg[a][k-1];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                grid[i][j] = view[s1_rsel_reg[i]][s1_csel_reg[j]];
            end
        end
    end

    assign job_push = s1_emit_reg;
    assign job_data = {s1_by_reg, s1_bx_reg, grid};

`ifndef SYNTH
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.restart |=> (c_reg == '0) && (r_reg == '0))
        else $error("frame restart did not clear the raster position");
`endif

endmodule
`default_nettype wire

FILE: sv/bdy_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdy_back
// Bilinear colour, luma and block chroma; hands out four results per block.
// ----------------------------------------------------------------------------
module bdy_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int JOB_W = bdy_pkg::GRID_W + CW + RW
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        job_empty,
    input  wire logic [JOB_W-1:0]            job_data,
    output logic                             job_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [bdy_pkg::OUT_W-1:0]        red,
    output logic [bdy_pkg::OUT_W-1:0]        green,
    output logic [bdy_pkg::OUT_W-1:0]        blue,
    output logic [bdy_pkg::OUT_W-1:0]        luma,
    output logic [bdy_pkg::OUT_W-1:0]        chroma_blue,
    output logic [bdy_pkg::OUT_W-1:0]        chroma_red,
    output logic [bdy_pkg::OCOL_W-1:0]       out_col,
    output logic [bdy_pkg::OROW_W-1:0]       out_row,
    output logic                             block_last
);

    bdy_pkg::grid_t g;
    logic [CW-1:0]  j_bx;
    logic [RW-1:0]  j_by;
    bdy_pkg::byte_t r_c [4];
    bdy_pkg::byte_t g_c [4];
    bdy_pkg::byte_t b_c [4];

    logic           b1_v_reg;
    bdy_pkg::byte_t b1_r_reg [4];
    bdy_pkg::byte_t b1_g_reg [4];
    bdy_pkg::byte_t b1_b_reg [4];
    logic [CW-1:0]  b1_bx_reg;
    logic [RW-1:0]  b1_by_reg;

    bdy_pkg::byte_t ra, ga, ba;
    logic [16:0]    cb_sum, cr_sum;
    logic [16:0]    y_sum [4];

    logic           blk_v_reg;
    logic [1:0]     idx_reg;
    bdy_pkg::byte_t blk_r_reg [4];
    bdy_pkg::byte_t blk_g_reg [4];
    bdy_pkg::byte_t blk_b_reg [4];
    bdy_pkg::byte_t blk_y_reg [4];
    bdy_pkg::byte_t blk_cb_reg, blk_cr_reg;
    logic [CW-1:0]  blk_bx_reg;
    logic [RW-1:0]  blk_by_reg;

    logic           pop_last, blk_load, b1_load;

    assign g    = job_data[bdy_pkg::GRID_W-1:0];
    assign j_bx = job_data[bdy_pkg::GRID_W +: CW];
    assign j_by = job_data[bdy_pkg::GRID_W + CW +: RW];

    // rows ym y0 y1 yp, columns xm x0 x1 xp
    always_comb
    begin
        r_c[0] = bdy_pkg::to8(g[1][1]);
        g_c[0] = bdy_pkg::to8(bdy_pkg::avg4(g[1][0], g[1][2], g[0][1], g[2][1]));
        b_c[0] = bdy_pkg::to8(bdy_pkg::avg4(g[0][0], g[0][2], g[2][0], g[2][2]));
        g_c[1] = bdy_pkg::to8(g[1][2]);
        r_c[1] = bdy_pkg::to8(bdy_pkg::avg2(g[1][1], g[1][3]));
        b_c[1] = bdy_pkg::to8(bdy_pkg::avg2(g[0][2], g[2][2]));
        g_c[2] = bdy_pkg::to8(g[2][1]);
        r_c[2] = bdy_pkg::to8(bdy_pkg::avg2(g[1][1], g[3][1]));
        b_c[2] = bdy_pkg::to8(bdy_pkg::avg2(g[2][0], g[2][2]));
        b_c[3] = bdy_pkg::to8(g[2][2]);
        g_c[3] = bdy_pkg::to8(bdy_pkg::avg4(g[2][1], g[2][3], g[1][2], g[3][2]));
        r_c[3] = bdy_pkg::to8(bdy_pkg::avg4(g[1][1], g[1][3], g[3][1], g[3][3]));
    end

    // block averages and weighted sums; the bias keeps chroma sums positive
    always_comb
    begin
        ra = 8'(bdy_pkg::avg4(10'(b1_r_reg[0]), 10'(b1_r_reg[1]),
                              10'(b1_r_reg[2]), 10'(b1_r_reg[3])));
        ga = 8'(bdy_pkg::avg4(10'(b1_g_reg[0]), 10'(b1_g_reg[1]),
                              10'(b1_g_reg[2]), 10'(b1_g_reg[3])));
        ba = 8'(bdy_pkg::avg4(10'(b1_b_reg[0]), 10'(b1_b_reg[1]),
                              10'(b1_b_reg[2]), 10'(b1_b_reg[3])));
        cb_sum = 17'(bdy_pkg::CB_B) * 17'(ba) + 17'(bdy_pkg::C_BIAS)
               - 17'(bdy_pkg::CB_R) * 17'(ra) - 17'(bdy_pkg::CB_G) * 17'(ga);
        cr_sum = 17'(bdy_pkg::CR_R) * 17'(ra) + 17'(bdy_pkg::C_BIAS)
               - 17'(bdy_pkg::CR_G) * 17'(ga) - 17'(bdy_pkg::CR_B) * 17'(ba);
        for (int k = 0; k < 4; k++)
        begin
            y_sum[k] = 17'(bdy_pkg::Y_R) * 17'(b1_r_reg[k])
                     + 17'(bdy_pkg::Y_G) * 17'(b1_g_reg[k])
                     + 17'(bdy_pkg::Y_B) * 17'(b1_b_reg[k])
                     + 17'(bdy_pkg::RND);
        end
    end

    assign pop_last = pop && blk_v_reg && (idx_reg == 2'd3);
    assign blk_load = b1_v_reg && (!blk_v_reg || pop_last);
    assign b1_load  = !job_empty && (!b1_v_reg || blk_load);
    assign job_pop  = b1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            blk_v_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (b1_load)
                b1_v_reg <= 1'b1;
            else if (blk_load)
                b1_v_reg <= 1'b0;
            if (blk_load)
            begin
                blk_v_reg <= 1'b1;
                idx_reg   <= 2'd0;
            end
            else if (pop && blk_v_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                    blk_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_load)
        begin
            b1_r_reg  <= r_c;
            b1_g_reg  <= g_c;
            b1_b_reg  <= b_c;
            b1_bx_reg <= j_bx;
            b1_by_reg <= j_by;
        end
        if (blk_load)
        begin
            blk_r_reg  <= b1_r_reg;
            blk_g_reg  <= b1_g_reg;
            blk_b_reg  <= b1_b_reg;
            for (int k = 0; k < 4; k++)
            begin
                blk_y_reg[k] <= y_sum[k][15:8] + 8'(bdy_pkg::Y_OFF);
            end
            blk_cb_reg <= cb_sum[15:8];
            blk_cr_reg <= cr_sum[15:8];
            blk_bx_reg <= b1_bx_reg;
            blk_by_reg <= b1_by_reg;
        end
    end

    // block origin is always even, so the pixel offset just fills bit 0
    assign empty       = !blk_v_reg;
    assign red         = blk_r_reg[idx_reg];
    assign green       = blk_g_reg[idx_reg];
    assign blue        = blk_b_reg[idx_reg];
    assign luma        = blk_y_reg[idx_reg];
    assign chroma_blue = blk_cb_reg;
    assign chroma_red  = blk_cr_reg;
    assign out_col     = 11'(blk_bx_reg) | 11'(idx_reg[0]);
    assign out_row     = 12'(blk_by_reg) | 12'(idx_reg[1]);
    assign block_last  = (idx_reg == 2'd3);

`ifndef SYNTH
    a_blk_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_v_reg && !pop_last) |=> blk_v_reg)
        else $error("block dropped before its last result was taken");
    a_blk_start: assert property (@(posedge clk) disable iff (!rst_n)
        blk_load |=> (idx_reg == 2'd0) && blk_v_reg)
        else $error("new block does not start at its top-left result");
`endif

endmodule
`default_nettype wire

FILE: sv/bayer_demosaic_yuv420_block_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_demosaic_yuv420_block_unit
// Bilinear RGGB demosaic with BT.601 luma and 2x2 block chroma.
// ----------------------------------------------------------------------------
// Input: 10-bit raw samples in raster order, pushed with push while full is
// low. Output: a queue read with pop while empty is low; each 2x2 block gives
// four results (top-left, top-right, bottom-left, bottom-right), block_last
// marking the fourth. A block is issued on the sample that completes its
// neighbourhood: two rows and two columns on, or the row end / last row.
// The first result passes the front's stage-1 registers, the request queue,
// then the b1 and block registers; the remaining three follow on consecutive cycles while pop is held.
// Throughput: one sample per cycle while full is low; the single result port
// hands out four results per block of four samples.
// The four line stores are one RAM per line, MAX_WIDTH deep, read and
// written once per sample.
// A request queue of four blocks separates the window front from the colour
// back; when the receiver stalls the back holds its block, the queue fills
// and full rises. Reset clears position and queues, not the line stores.
// Width and height registers (APB, addresses 0 and 4) take effect at once and
// restart the frame; write them only while the block is idle.
// ----------------------------------------------------------------------------
module bayer_demosaic_yuv420_block_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bdy_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bdy_pkg::APB_DW-1:0]   pwdata,
    output logic      [bdy_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [bdy_pkg::PIX_W-1:0]    raw_pixel,
    output logic                              empty,
    input  wire logic                         pop,
    output logic      [bdy_pkg::OUT_W-1:0]    red,
    output logic      [bdy_pkg::OUT_W-1:0]    green,
    output logic      [bdy_pkg::OUT_W-1:0]    blue,
    output logic      [bdy_pkg::OUT_W-1:0]    luma,
    output logic      [bdy_pkg::OUT_W-1:0]    chroma_blue,
    output logic      [bdy_pkg::OUT_W-1:0]    chroma_red,
    output logic      [bdy_pkg::OCOL_W-1:0]   out_col,
    output logic      [bdy_pkg::OROW_W-1:0]   out_row,
    output logic                              block_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int JOB_W = bdy_pkg::GRID_W + CW + RW;

    logic [bdy_pkg::WP_W-1:0] wp_reg;
    logic [bdy_pkg::HP_W-1:0] hp_reg;
    logic                     wr;
    bdy_pkg::cfg_t            cfg;
    logic                     q_afull, q_empty, q_push, q_pop;
    logic [JOB_W-1:0]         q_wdata, q_rdata;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= bdy_pkg::WP_RESET;
            hp_reg <= bdy_pkg::HP_RESET;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                bdy_pkg::REG_WIDTH_PAIRS:  wp_reg <= pwdata[bdy_pkg::WP_W-1:0];
                bdy_pkg::REG_HEIGHT_PAIRS: hp_reg <= pwdata[bdy_pkg::HP_W-1:0];
                default:                   wp_reg <= wp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bdy_pkg::REG_WIDTH_PAIRS:  prdata = 32'(wp_reg);
            bdy_pkg::REG_HEIGHT_PAIRS: prdata = 32'(hp_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = '{width_pairs: wp_reg, height_pairs: hp_reg, restart: wr};

    bdy_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .raw_pixel (raw_pixel),
        .full      (full),
        .q_afull   (q_afull),
        .job_push  (q_push),
        .job_data  (q_wdata)
    );

    bdy_jobq #(
        .WIDTH (JOB_W),
        .DEPTH (4)
    ) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .afull (q_afull)
    );

    bdy_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_empty   (q_empty),
        .job_data    (q_rdata),
        .job_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .out_col     (out_col),
        .out_row     (out_row),
        .block_last  (block_last)
    );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bayer demosaic / YUV 4:2:0 block unit.
// ----------------------------------------------------------------------------
// Pushes raw RGGB frames of many sizes through the queue-style input, with
// register writes between phases, predicts every result with a bit-exact
// model held in a scoreboard and compares each popped result in order.
// Both sides idle in random bursts; once the receiver holds off long enough
// for the block to fill up and raise full.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_LEN  = 2048;
    localparam int MAX_CYCLE = 1000000;

    typedef struct packed {
        bdy_pkg::byte_t              red;
        bdy_pkg::byte_t              green;
        bdy_pkg::byte_t              blue;
        bdy_pkg::byte_t              luma;
        bdy_pkg::byte_t              chroma_blue;
        bdy_pkg::byte_t              chroma_red;
        logic [bdy_pkg::OCOL_W-1:0]  out_col;
        logic [bdy_pkg::OROW_W-1:0]  out_row;
        logic                        block_last;
    } rgb_yuv_t;

    class demosaic_scoreboard;
        bdy_pkg::pix_t lines [4][LINE_LEN];
        int            col_n, row_n, slot;
        int            wpairs, hpairs;
        rgb_yuv_t      expected_px [$];
        int            errors;

        function new();
            wpairs = int'(bdy_pkg::WP_RESET);
            hpairs = int'(bdy_pkg::HP_RESET);
        endfunction

        function void write_reg(logic idx, int value);
            if (idx == bdy_pkg::REG_WIDTH_PAIRS) wpairs = value & 'h7FF;
            else hpairs = value & 'hFFF;
            col_n = 0;
            row_n = 0;
            slot  = 0;
        endfunction

        function int px(int r, int c);
            return int'(lines[r & 3][c]);
        endfunction

        function int reduce8(int v);
            v = (v + 2) >> 2;
            return v > 255 ? 255 : v;
        endfunction

        function int clamp8(int v);
            return v < 0 ? 0 : (v > 255 ? 255 : v);
        endfunction

        function void emit_block(int by, int bx, int w, int h);
            int ym, y0, y1, yp, xm, x0, x1, xp;
            int r [4];
            int g [4];
            int b [4];
            int ra, ga, ba, cb, cr, yv;
            rgb_yuv_t o;
            ym = by > 0 ? by - 1 : by;
            y0 = by;
            y1 = by + 1;
            yp = (by + 2 < h) ? by + 2 : y1;
            xm = bx > 0 ? bx - 1 : bx;
            x0 = bx;
            x1 = bx + 1;
            xp = (bx + 2 < w) ? bx + 2 : x1;
            r[0] = px(y0, x0);
            g[0] = (px(y0, xm) + px(y0, x1) + px(ym, x0) + px(y1, x0)) >> 2;
            b[0] = (px(ym, xm) + px(ym, x1) + px(y1, xm) + px(y1, x1)) >> 2;
            g[1] = px(y0, x1);
            r[1] = (px(y0, x0) + px(y0, xp)) >> 1;
            b[1] = (px(ym, x1) + px(y1, x1)) >> 1;
            g[2] = px(y1, x0);
            r[2] = (px(y0, x0) + px(yp, x0)) >> 1;
            b[2] = (px(y1, xm) + px(y1, x1)) >> 1;
            b[3] = px(y1, x1);
            g[3] = (px(y1, x0) + px(y1, xp) + px(y0, x1) + px(yp, x1)) >> 2;
            r[3] = (px(y0, x0) + px(y0, xp) + px(yp, x0) + px(yp, xp)) >> 2;
            for (int k = 0; k < 4; k++)
            begin
                r[k] = reduce8(r[k]);
                g[k] = reduce8(g[k]);
                b[k] = reduce8(b[k]);
            end
            ra = (r[0] + r[1] + r[2] + r[3]) >> 2;
            ga = (g[0] + g[1] + g[2] + g[3]) >> 2;
            ba = (b[0] + b[1] + b[2] + b[3]) >> 2;
            cb = clamp8((-bdy_pkg::CB_R * ra - bdy_pkg::CB_G * ga + bdy_pkg::CB_B * ba
                         + bdy_pkg::C_BIAS) >>> 8);
            cr = clamp8((bdy_pkg::CR_R * ra - bdy_pkg::CR_G * ga - bdy_pkg::CR_B * ba
                         + bdy_pkg::C_BIAS) >>> 8);
            for (int k = 0; k < 4; k++)
            begin
                yv = ((bdy_pkg::Y_R * r[k] + bdy_pkg::Y_G * g[k] + bdy_pkg::Y_B * b[k]
                       + bdy_pkg::RND) >> 8) + bdy_pkg::Y_OFF;
                o.red         = 8'(r[k]);
                o.green       = 8'(g[k]);
                o.blue        = 8'(b[k]);
                o.luma        = 8'(yv > 255 ? 255 : yv);
                o.chroma_blue = 8'(cb);
                o.chroma_red  = 8'(cr);
                o.out_col     = bdy_pkg::OCOL_W'(bx + (k & 1));
                o.out_row     = bdy_pkg::OROW_W'(by + (k >> 1));
                o.block_last  = (k == 3);
                expected_px.push_back(o);
            end
        endfunction

        function void note_pixel(bdy_pkg::pix_t v);
            int w, h, r, c, by, bx;
            bit row_ok, col_ok;
            w = 2 * (wpairs < 1 ? 1 : (wpairs > LINE_LEN / 2 ? LINE_LEN / 2 : wpairs));
            h = 2 * (hpairs < 1 ? 1 : (hpairs > 2048 ? 2048 : hpairs));
            if (col_n >= w) col_n = 0;
            if (row_n >= h) row_n = 0;
            r = row_n;
            c = col_n;
            lines[slot][c] = v;
            row_ok = 0;
            col_ok = 0;
            if ((r & 1) == 0 && r >= 2)
            begin
                row_ok = 1;
                by = r - 2;
            end
            else if (r == h - 1)
            begin
                row_ok = 1;
                by = h - 2;
            end
            if ((c & 1) == 0 && c >= 2)
            begin
                col_ok = 1;
                bx = c - 2;
            end
            else if (c == w - 1)
            begin
                col_ok = 1;
                bx = w - 2;
            end
            if (row_ok && col_ok) emit_block(by, bx, w, h);
            if (c + 1 >= w)
            begin
                col_n = 0;
                if (r + 1 >= h)
                begin
                    row_n = 0;
                    slot  = 0;
                end
                else
                begin
                    row_n = r + 1;
                    slot  = (slot + 1) & 3;
                end
            end
            else
            begin
                col_n = c + 1;
            end
        endfunction

        function void check_result(rgb_yuv_t got);
            rgb_yuv_t want;
            if (expected_px.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = expected_px.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at row %0d col %0d\n  expected %p\n  actual   %p",
                             want.out_row, want.out_col, want, got);
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [bdy_pkg::APB_AW-1:0]  paddr = '0;
    logic [bdy_pkg::APB_DW-1:0]  pwdata = '0;
    logic [bdy_pkg::APB_DW-1:0]  prdata;
    logic                        pready;
    logic                        push = 1'b0;
    logic                        full;
    bdy_pkg::pix_t               raw_pixel = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    rgb_yuv_t                    res;

    demosaic_scoreboard  sb = new();
    int                  pixels_sent;
    int                  cycle_n;
    bit                  no_idle;
    bit                  long_hold_req;

    bayer_demosaic_yuv420_block_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .raw_pixel   (raw_pixel),
        .empty       (empty),
        .pop         (pop),
        .red         (res.red),
        .green       (res.green),
        .blue        (res.blue),
        .luma        (res.luma),
        .chroma_blue (res.chroma_blue),
        .chroma_red  (res.chroma_red),
        .out_col     (res.out_col),
        .out_row     (res.out_row),
        .block_last  (res.block_last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n > MAX_CYCLE)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && push && !full) sb.note_pixel(raw_pixel);
        if (rst_n && pop && !empty) sb.check_result(res);
    end

    // receiver: random stalls, plus one long hold-off to fill the block
    initial
    begin
        int idle_left;
        idle_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                idle_left = 300;
            end
            if (idle_left > 0)
            begin
                pop = 1'b0;
                idle_left--;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                pop = 1'b0;
                idle_left = $urandom_range(1, 15) - 1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    task automatic send_pixel(bdy_pkg::pix_t v);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        push = 1'b1;
        raw_pixel = v;
        do @(posedge clk); while (full);
        pixels_sent++;
    endtask

    task automatic apb_write(logic idx, int value);
        @(negedge clk);
        push    = 1'b0;
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.write_reg(idx, value);
    endtask

    // drain all outstanding requests, then set the frame size
    task automatic set_frame(int wp, int hp);
        @(negedge clk);
        push = 1'b0;
        while (sb.expected_px.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        apb_write(bdy_pkg::REG_WIDTH_PAIRS, wp);
        apb_write(bdy_pkg::REG_HEIGHT_PAIRS, hp);
    endtask

    function automatic bdy_pkg::pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 10'd1023;
            2: return 10'd1022;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    initial
    begin
        int wp, hp, n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default size: a few samples, no block completes
        repeat (3) send_pixel(rand_pixel());
        // smallest frame, saturating samples, then frame wrap
        set_frame(1, 1);
        repeat (4) send_pixel(10'd1023);
        send_pixel(10'd1022);
        send_pixel('0);
        send_pixel(10'd1);
        send_pixel(10'd1022);
        // out-of-range registers clamp
        set_frame(0, 0);
        send_pixel('0);
        send_pixel(10'd1023);
        send_pixel(10'd1023);
        send_pixel('0);
        // 4x4 frame, then a partial frame cut short by a restart
        set_frame(2, 2);
        repeat (16) send_pixel(rand_pixel());
        repeat (5) send_pixel(rand_pixel());
        set_frame(2, 2);
        repeat (8) send_pixel(rand_pixel());

        // widest line, start of its first row only; then tallest frame, first rows only
        set_frame(2047, 1);
        repeat (24) send_pixel(10'($urandom_range(0, 1023)));
        set_frame(1, 4095);
        repeat (12) send_pixel(rand_pixel());

        set_frame(4, 3);
        long_hold_req = 1;
        repeat (48) send_pixel(rand_pixel());

        n = pixels_sent;
        while (pixels_sent - n < 200)
        begin
            if (pixels_sent - n > 150) no_idle = 1;
            wp = $urandom_range(1, 6);
            hp = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0: wp = 0;
                1: hp = 0;
                2: wp = 1500;
                default: ;
            endcase
            set_frame(wp, hp);
            if (wp == 1500) wp = 2;
            if (wp == 0) wp = 1;
            if (hp == 0) hp = 1;
            repeat ($urandom_range(1, 2) * 4 * wp * hp) send_pixel(rand_pixel());
            // occasionally leave a frame unfinished
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5)) send_pixel(rand_pixel());
        end

        @(negedge clk);
        push = 1'b0;
        while (sb.expected_px.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_px.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/bdy_pkg.sv
sv/bdy_ram.sv
sv/bdy_jobq.sv
sv/bdy_front.sv
sv/bdy_back.sv
sv/bayer_demosaic_yuv420_block_unit.sv
dv/testbench.sv
